// File: rtl/ipc_pkg.sv
package ipc_pkg;

    // Field widths
    localparam int ADC_BITS   = 12;
    localparam int FRAC_BITS  = 15;
    localparam int SCALE_W    = 16;
    localparam int REF_W      = 32;
    localparam int COEF_W     = 16;
    localparam int OUT_W      = 15;
    localparam int DUTY_SHIFT = 5;
    localparam int DUTY_W     = OUT_W - DUTY_SHIFT;
    localparam int LIMIT_W    = 20;
    localparam int CFG_W      = 32;
    localparam int CFG_IDX_W  = 3;

    // Datapath widths: error spans the reference range plus the scaled sample
    localparam int ERR_W   = REF_W + 2;
    localparam int MB_W    = SCALE_W + 1;
    localparam int PROD_W  = ERR_W + MB_W;
    localparam int TERM_W  = PROD_W - FRAC_BITS;
    localparam int ACC_W   = TERM_W + 2;
    localparam int UPREV_W = LIMIT_W + 1;

    // Stream word widths
    localparam int IN_TDATA_W  = ((ADC_BITS + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((OUT_W + DUTY_W + 7) / 8) * 8;

    // Register reset values
    localparam logic [SCALE_W-1:0] RST_INPUT_SCALE = SCALE_W'(508);
    localparam logic [REF_W-1:0]   RST_REFERENCE   = REF_W'(-163840);
    localparam logic [COEF_W-1:0]  RST_COEF_NOW    = COEF_W'(256);
    localparam logic [COEF_W-1:0]  RST_COEF_PREV   = COEF_W'(-444);
    localparam logic [COEF_W-1:0]  RST_COEF_PREV2  = COEF_W'(230);
    localparam logic [OUT_W-1:0]   RST_OUT_MAX     = OUT_W'(16'h599A);
    localparam logic [LIMIT_W-1:0] RST_STATE_LIMIT = LIMIT_W'(45876);

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_INPUT_SCALE = 3'd0,
        REG_REFERENCE   = 3'd1,
        REG_COEF_NOW    = 3'd2,
        REG_COEF_PREV   = 3'd3,
        REG_COEF_PREV2  = 3'd4,
        REG_OUT_MAX     = 3'd5,
        REG_STATE_LIMIT = 3'd6
    } cfg_idx_t;

    // Microcode fields
    localparam int STEP_W = 3;

    typedef enum logic [1:0] {
        OP_SCALE = 2'd0,   // sample * input_scale
        OP_NOW   = 2'd1,   // err * coef_now
        OP_PREV  = 2'd2,   // e1 * coef_prev
        OP_PREV2 = 2'd3    // e2 * coef_prev2
    } mul_op_t;

    typedef enum logic [1:0] {
        ACC_NOP  = 2'd0,
        ACC_LOAD = 2'd1,   // acc = u1
        ACC_ADD  = 2'd2    // acc += product >>> FRAC_BITS
    } acc_op_t;

    typedef enum logic [1:0] {
        JMP_SEQ    = 2'd0,
        JMP_FIRST  = 2'd1,
        JMP_ALWAYS = 2'd2
    } jmp_t;

    typedef struct packed {
        mul_op_t           mul_op;
        logic              mul_en;
        acc_op_t           acc_op;
        logic              err_ld;
        logic              prime;
        logic              fin;
        logic              done;
        jmp_t              jmp;
        logic [STEP_W-1:0] target;
    } ctrl_t;

    // Step addresses
    localparam logic [STEP_W-1:0] ST_SCALE = 3'd0;
    localparam logic [STEP_W-1:0] ST_ERR   = 3'd1;
    localparam logic [STEP_W-1:0] ST_B0    = 3'd2;
    localparam logic [STEP_W-1:0] ST_B1    = 3'd3;
    localparam logic [STEP_W-1:0] ST_B2    = 3'd4;
    localparam logic [STEP_W-1:0] ST_SUM   = 3'd5;
    localparam logic [STEP_W-1:0] ST_FIN   = 3'd6;
    localparam logic [STEP_W-1:0] ST_PRIME = 3'd7;

    // Control store
    function automatic ctrl_t ctrl_rom(input logic [STEP_W-1:0] step);
        ctrl_t c;
        c = '{mul_op: OP_SCALE, mul_en: 1'b0, acc_op: ACC_NOP, err_ld: 1'b0,
              prime: 1'b0, fin: 1'b0, done: 1'b0, jmp: JMP_SEQ, target: ST_SCALE};
        case (step)
            ST_SCALE:
            begin
                c.mul_op = OP_SCALE;
                c.mul_en = 1'b1;
            end
            ST_ERR:
            begin
                c.err_ld = 1'b1;
                c.jmp    = JMP_FIRST;
                c.target = ST_PRIME;
            end
            ST_B0:
            begin
                c.mul_op = OP_NOW;
                c.mul_en = 1'b1;
                c.acc_op = ACC_LOAD;
            end
            ST_B1:
            begin
                c.mul_op = OP_PREV;
                c.mul_en = 1'b1;
                c.acc_op = ACC_ADD;
            end
            ST_B2:
            begin
                c.mul_op = OP_PREV2;
                c.mul_en = 1'b1;
                c.acc_op = ACC_ADD;
            end
            ST_SUM:
            begin
                c.acc_op = ACC_ADD;
            end
            ST_FIN:
            begin
                c.fin  = 1'b1;
                c.done = 1'b1;
            end
            ST_PRIME:
            begin
                c.prime  = 1'b1;
                c.jmp    = JMP_ALWAYS;
                c.target = ST_B0;
            end
            default:
            begin
                c.done = 1'b1;
            end
        endcase
        return c;
    endfunction

endpackage

// File: rtl/ipc_seq.sv
// Step counter and control store for the compensator datapath
module ipc_seq (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic            first,
    input  logic            hold,
    output logic            busy,
    output ipc_pkg::ctrl_t  ctrl
);

    logic                       busy_reg;
    logic [ipc_pkg::STEP_W-1:0] step_reg;
    logic [ipc_pkg::STEP_W-1:0] step_next;

    assign ctrl = ipc_pkg::ctrl_rom(step_reg);
    assign busy = busy_reg;

    // Next step: fall through or take the jump
    always_comb
    begin
        case (ctrl.jmp)
            ipc_pkg::JMP_FIRST:  step_next = first ? ctrl.target : step_reg + 1'b1;
            ipc_pkg::JMP_ALWAYS: step_next = ctrl.target;
            default:             step_next = step_reg + 1'b1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= ipc_pkg::ST_SCALE;
        end
        else if (!busy_reg)
        begin
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= ipc_pkg::ST_SCALE;
            end
        end
        else if (!hold)
        begin
            if (ctrl.done)
                busy_reg <= 1'b0;
            else
                step_reg <= step_next;
        end
    end

    // Program flow checks
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy_reg) |=> (busy_reg && step_reg == ipc_pkg::ST_SCALE))
        else $error("sequencer did not start at the first step");
    a_hold_fin: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && hold) |-> ctrl.fin)
        else $error("hold outside the finish step");
    a_prime_first: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && step_reg == ipc_pkg::ST_PRIME) |-> $past(first))
        else $error("prime step taken without first sample");

endmodule

// File: rtl/incremental_pid_compensator_core.sv
// Incremental PID compensator: one 12-bit sample in, one clamped control
// word and 10-bit duty out. A sample is taken when the block is ready; it
// is then scaled, the error formed and the three coefficient products
// summed (the first sample after reset adds a step that primes the error
// history). The block is ready again as the result word appears, and takes
// a new sample only once it is through with the last one. A single 34x17
// multiplier is shared by the scale and the three coefficient products
// under a small microcoded sequencer. A finished result waits in an output
// register; the next sample is accepted meanwhile, and the block only
// pauses at its finish step while an older result is still not taken.
module incremental_pid_compensator_core (
    input  logic                                clk,
    input  logic                                rst_n,
    // Sample stream
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [ipc_pkg::IN_TDATA_W-1:0]      s_axis_tdata,   // [11:0] adc_sample
    // Result stream
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [ipc_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,   // [14:0] control_out,
                                                                // [24:15] duty_word
    // Register writes
    input  logic                                cfg_we,
    input  logic [ipc_pkg::CFG_IDX_W-1:0]       cfg_addr,
    input  logic [ipc_pkg::CFG_W-1:0]           cfg_wdata
);

    // Configuration registers
    logic [ipc_pkg::SCALE_W-1:0]        input_scale_reg;
    logic [ipc_pkg::REF_W-1:0]          reference_reg;
    logic [ipc_pkg::COEF_W-1:0]         coef_now_reg;
    logic [ipc_pkg::COEF_W-1:0]         coef_prev_reg;
    logic [ipc_pkg::COEF_W-1:0]         coef_prev2_reg;
    logic [ipc_pkg::OUT_W-1:0]          out_max_reg;
    logic [ipc_pkg::LIMIT_W-1:0]        state_limit_reg;

    // Loop state and datapath
    logic                               first_reg;
    logic [ipc_pkg::ADC_BITS-1:0]       sample_reg;
    logic signed [ipc_pkg::ERR_W-1:0]   err_reg;
    logic signed [ipc_pkg::ERR_W-1:0]   e1_reg;
    logic signed [ipc_pkg::ERR_W-1:0]   e2_reg;
    logic signed [ipc_pkg::UPREV_W-1:0] u1_reg;
    logic signed [ipc_pkg::PROD_W-1:0]  prod_reg;
    logic signed [ipc_pkg::ACC_W-1:0]   acc_reg;

    // Output register
    logic                               out_valid_reg;
    logic [ipc_pkg::OUT_W-1:0]          out_ctl_reg;
    logic [ipc_pkg::DUTY_W-1:0]         out_duty_reg;

    logic                               busy;
    logic                               hold;
    logic                               step_go;
    logic                               fin_go;
    logic                               in_go;
    ipc_pkg::ctrl_t                     ctrl;

    logic signed [ipc_pkg::ERR_W-1:0]   mul_a;
    logic signed [ipc_pkg::MB_W-1:0]    mul_b;
    logic signed [ipc_pkg::PROD_W-1:0]  mul_p;
    logic signed [ipc_pkg::ERR_W-1:0]   err_calc;
    logic signed [ipc_pkg::TERM_W-1:0]  term;
    logic signed [ipc_pkg::ACC_W-1:0]   lim_pos;
    logic signed [ipc_pkg::ACC_W-1:0]   lim_neg;
    logic signed [ipc_pkg::ACC_W-1:0]   omax;
    logic signed [ipc_pkg::ACC_W-1:0]   u_state;
    logic [ipc_pkg::OUT_W-1:0]          y;

    // Handshakes
    assign s_axis_tready = !busy;
    assign in_go         = s_axis_tvalid && !busy;
    assign hold          = ctrl.fin && out_valid_reg && !m_axis_tready;
    assign step_go       = busy && !hold;
    assign fin_go        = step_go && ctrl.fin;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(ipc_pkg::OUT_TDATA_W - ipc_pkg::OUT_W - ipc_pkg::DUTY_W){1'b0}},
                            out_duty_reg, out_ctl_reg};

    ipc_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .start (in_go),
        .first (first_reg),
        .hold  (hold),
        .busy  (busy),
        .ctrl  (ctrl)
    );

    // Register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            input_scale_reg <= ipc_pkg::RST_INPUT_SCALE;
            reference_reg   <= ipc_pkg::RST_REFERENCE;
            coef_now_reg    <= ipc_pkg::RST_COEF_NOW;
            coef_prev_reg   <= ipc_pkg::RST_COEF_PREV;
            coef_prev2_reg  <= ipc_pkg::RST_COEF_PREV2;
            out_max_reg     <= ipc_pkg::RST_OUT_MAX;
            state_limit_reg <= ipc_pkg::RST_STATE_LIMIT;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                ipc_pkg::REG_INPUT_SCALE: input_scale_reg <= cfg_wdata[ipc_pkg::SCALE_W-1:0];
                ipc_pkg::REG_REFERENCE:   reference_reg   <= cfg_wdata[ipc_pkg::REF_W-1:0];
                ipc_pkg::REG_COEF_NOW:    coef_now_reg    <= cfg_wdata[ipc_pkg::COEF_W-1:0];
                ipc_pkg::REG_COEF_PREV:   coef_prev_reg   <= cfg_wdata[ipc_pkg::COEF_W-1:0];
                ipc_pkg::REG_COEF_PREV2:  coef_prev2_reg  <= cfg_wdata[ipc_pkg::COEF_W-1:0];
                ipc_pkg::REG_OUT_MAX:     out_max_reg     <= cfg_wdata[ipc_pkg::OUT_W-1:0];
                ipc_pkg::REG_STATE_LIMIT: state_limit_reg <= cfg_wdata[ipc_pkg::LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    // Shared multiplier operand select
    always_comb
    begin
        case (ctrl.mul_op)
            ipc_pkg::OP_SCALE:
            begin
                mul_a = ipc_pkg::ERR_W'(sample_reg);
                mul_b = ipc_pkg::MB_W'(input_scale_reg);
            end
            ipc_pkg::OP_NOW:
            begin
                mul_a = err_reg;
                mul_b = ipc_pkg::MB_W'($signed(coef_now_reg));
            end
            ipc_pkg::OP_PREV:
            begin
                mul_a = e1_reg;
                mul_b = ipc_pkg::MB_W'($signed(coef_prev_reg));
            end
            default:
            begin
                mul_a = e2_reg;
                mul_b = ipc_pkg::MB_W'($signed(coef_prev2_reg));
            end
        endcase
    end

    assign mul_p    = mul_a * mul_b;
    assign err_calc = $signed(prod_reg[ipc_pkg::ERR_W-1:0])
                    - ipc_pkg::ERR_W'($signed(reference_reg));
    assign term     = prod_reg[ipc_pkg::PROD_W-1:ipc_pkg::FRAC_BITS];

    // Output and state clamps
    assign lim_pos = ipc_pkg::ACC_W'($signed({1'b0, state_limit_reg}));
    assign lim_neg = -lim_pos;
    assign omax    = ipc_pkg::ACC_W'($signed({1'b0, out_max_reg}));

    always_comb
    begin
        if (acc_reg < 0)
            y = '0;
        else if (acc_reg > omax)
            y = out_max_reg;
        else
            y = acc_reg[ipc_pkg::OUT_W-1:0];

        if (acc_reg < lim_neg)
            u_state = lim_neg;
        else if (acc_reg > lim_pos)
            u_state = lim_pos;
        else
            u_state = acc_reg;
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (in_go)
            sample_reg <= s_axis_tdata[ipc_pkg::ADC_BITS-1:0];

        if (step_go && ctrl.mul_en)
            prod_reg <= mul_p;

        if (step_go && ctrl.err_ld)
            err_reg <= err_calc;

        if (step_go)
        begin
            case (ctrl.acc_op)
                ipc_pkg::ACC_LOAD: acc_reg <= ipc_pkg::ACC_W'(u1_reg);
                ipc_pkg::ACC_ADD:  acc_reg <= acc_reg + ipc_pkg::ACC_W'(term);
                default: ;
            endcase
        end
    end

    // Error history and stored output
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg <= 1'b1;
            e1_reg    <= '0;
            e2_reg    <= '0;
            u1_reg    <= '0;
        end
        else if (step_go && ctrl.prime)
        begin
            e1_reg <= err_reg;
            e2_reg <= err_reg;
            u1_reg <= '0;
        end
        else if (fin_go)
        begin
            first_reg <= 1'b0;
            e2_reg    <= e1_reg;
            e1_reg    <= err_reg;
            u1_reg    <= u_state[ipc_pkg::UPREV_W-1:0];
        end
    end

    // Result word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (fin_go)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (fin_go)
        begin
            out_ctl_reg  <= y;
            out_duty_reg <= y[ipc_pkg::OUT_W-1:ipc_pkg::DUTY_SHIFT];
        end
    end

    // Checks
    a_word_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(fin_go))
        else $error("result word appeared without a finish step");
    a_first_clear: assert property (@(posedge clk) disable iff (!rst_n)
        fin_go |=> !first_reg)
        else $error("first-sample flag still set after a result");
    a_state_clamp: assert property (@(posedge clk) disable iff (!rst_n)
        fin_go |=> (($signed(u1_reg) <= $signed({1'b0, $past(state_limit_reg)}))
                 && ($signed(u1_reg) >= -$signed({1'b0, $past(state_limit_reg)}))))
        else $error("stored output outside the state limit");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> busy)
        else $error("accepted sample did not start the sequencer");

endmodule

// File: dv/tb_incremental_pid_compensator_core.sv
`timescale 1ns / 100ps

module tb_incremental_pid_compensator_core;

    localparam int CYCLE_LIMIT = 400000;
    localparam int REPORT_MAX  = 10;
    localparam int ITEMS_PHASE = 350;
    localparam int ITEMS_SET   = 50;
    localparam logic [ipc_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;   // decodes to nothing

    // One result word: control output and duty
    typedef struct packed {
        logic [ipc_pkg::OUT_W-1:0]  ctl;
        logic [ipc_pkg::DUTY_W-1:0] duty;
    } ctl_word_t;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [ipc_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [ipc_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
    logic                            cfg_we = 1'b0;
    logic [ipc_pkg::CFG_IDX_W-1:0]   cfg_addr = '0;
    logic [ipc_pkg::CFG_W-1:0]       cfg_wdata = '0;

    // Compensator register copy
    logic        [ipc_pkg::SCALE_W-1:0] scale_r    = ipc_pkg::RST_INPUT_SCALE;
    logic signed [ipc_pkg::REF_W-1:0]   setpoint_r = ipc_pkg::RST_REFERENCE;
    logic signed [ipc_pkg::COEF_W-1:0]  b_now      = ipc_pkg::RST_COEF_NOW;
    logic signed [ipc_pkg::COEF_W-1:0]  b_prev     = ipc_pkg::RST_COEF_PREV;
    logic signed [ipc_pkg::COEF_W-1:0]  b_prev2    = ipc_pkg::RST_COEF_PREV2;
    logic        [ipc_pkg::OUT_W-1:0]   out_max_r  = ipc_pkg::RST_OUT_MAX;
    logic        [ipc_pkg::LIMIT_W-1:0] limit_r    = ipc_pkg::RST_STATE_LIMIT;

    // Compensator history copy
    bit     first_sample = 1'b1;
    longint err_d1 = 0;
    longint err_d2 = 0;
    longint out_d1 = 0;

    ctl_word_t pending_ctl_q[$];

    int send_idle_pct   = 0;
    int recv_stall_pct  = 0;
    int fail_count      = 0;
    int samples_sent    = 0;
    int results_checked = 0;
    int settings_loaded = 0;

    incremental_pid_compensator_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // Run guard
    initial
    begin
        for (int cyc = 0; cyc < CYCLE_LIMIT; cyc++)
            @(posedge clk);
        $display("Timeout after %0d cycles, %0d results outstanding",
                 CYCLE_LIMIT, pending_ctl_q.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Velocity-form PID step; advances the history copy
    function automatic ctl_word_t compute_control(input logic [ipc_pkg::ADC_BITS-1:0] smp);
        longint    err;
        longint    acc;
        longint    clamped;
        longint    lim;
        ctl_word_t r;
        err = longint'(smp) * longint'(scale_r) - longint'(setpoint_r);
        if (first_sample)
        begin
            err_d1       = err;
            err_d2       = err;
            out_d1       = 0;
            first_sample = 1'b0;
        end
        acc = ((err * longint'(b_now)) >>> ipc_pkg::FRAC_BITS)
            + ((err_d1 * longint'(b_prev)) >>> ipc_pkg::FRAC_BITS)
            + ((err_d2 * longint'(b_prev2)) >>> ipc_pkg::FRAC_BITS)
            + out_d1;
        clamped = (acc < 0) ? 0 : ((acc > longint'(out_max_r)) ? longint'(out_max_r) : acc);
        lim     = longint'(limit_r);
        out_d1  = (acc < -lim) ? -lim : ((acc > lim) ? lim : acc);
        err_d2  = err_d1;
        err_d1  = err;
        r.ctl   = ipc_pkg::OUT_W'(clamped);
        r.duty  = ipc_pkg::DUTY_W'(clamped >>> ipc_pkg::DUTY_SHIFT);
        return r;
    endfunction

    function automatic logic [31:0] pick_edge(input logic [31:0] lo, input logic [31:0] hi,
                                              input logic [31:0] rnd);
        case ($urandom_range(2))
            0:       return lo;
            1:       return hi;
            default: return rnd;
        endcase
    endfunction

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= REPORT_MAX)
            $display("[%0t] %s", $realtime, msg);
    endtask

    // Result receiver: random stall
    always @(posedge clk)
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);

    // Result checker
    always @(posedge clk)
    begin : result_check
        ctl_word_t                  want;
        logic [ipc_pkg::OUT_W-1:0]  got_ctl;
        logic [ipc_pkg::DUTY_W-1:0] got_duty;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got_ctl  = m_axis_tdata[ipc_pkg::OUT_W-1:0];
            got_duty = m_axis_tdata[ipc_pkg::OUT_W +: ipc_pkg::DUTY_W];
            if (pending_ctl_q.size() == 0)
                note_failure($sformatf("unexpected word: control %0d duty %0d",
                                       got_ctl, got_duty));
            else
            begin
                want = pending_ctl_q.pop_front();
                results_checked++;
                if (want.ctl !== got_ctl || want.duty !== got_duty)
                    note_failure($sformatf(
                        "mismatch: control exp %0d got %0d, duty exp %0d got %0d",
                        want.ctl, got_ctl, want.duty, got_duty));
            end
        end
    end

    // Send one sample and queue its predicted word
    task automatic send_sample(input logic [ipc_pkg::ADC_BITS-1:0] smp);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= ipc_pkg::IN_TDATA_W'(smp);
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        pending_ctl_q.push_back(compute_control(smp));
        samples_sent++;
    endtask

    task automatic write_reg(input logic [ipc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [ipc_pkg::CFG_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        case (idx)
            ipc_pkg::REG_INPUT_SCALE: scale_r    = data[ipc_pkg::SCALE_W-1:0];
            ipc_pkg::REG_REFERENCE:   setpoint_r = data[ipc_pkg::REF_W-1:0];
            ipc_pkg::REG_COEF_NOW:    b_now      = data[ipc_pkg::COEF_W-1:0];
            ipc_pkg::REG_COEF_PREV:   b_prev     = data[ipc_pkg::COEF_W-1:0];
            ipc_pkg::REG_COEF_PREV2:  b_prev2    = data[ipc_pkg::COEF_W-1:0];
            ipc_pkg::REG_OUT_MAX:     out_max_r  = data[ipc_pkg::OUT_W-1:0];
            ipc_pkg::REG_STATE_LIMIT: limit_r    = data[ipc_pkg::LIMIT_W-1:0];
            default:                  ;
        endcase
    endtask

    // Drain, then write every register; junk goes in the unused upper bits
    task automatic load_settings(input logic [ipc_pkg::SCALE_W-1:0] sc, input logic [31:0] sp,
                                 input logic [15:0] c0, input logic [15:0] c1,
                                 input logic [15:0] c2, input logic [ipc_pkg::OUT_W-1:0] om,
                                 input logic [ipc_pkg::LIMIT_W-1:0] lm);
        s_axis_tvalid <= 1'b0;
        while (pending_ctl_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        write_reg(ipc_pkg::REG_INPUT_SCALE, {16'($urandom()), sc});
        write_reg(ipc_pkg::REG_REFERENCE,   sp);
        write_reg(ipc_pkg::REG_COEF_NOW,    {16'($urandom()), c0});
        write_reg(ipc_pkg::REG_COEF_PREV,   {16'($urandom()), c1});
        write_reg(ipc_pkg::REG_COEF_PREV2,  {16'($urandom()), c2});
        write_reg(ipc_pkg::REG_OUT_MAX,     {17'($urandom()), om});
        write_reg(ipc_pkg::REG_STATE_LIMIT, {12'($urandom()), lm});
        if ($urandom_range(1) == 0)
            write_reg(REG_UNUSED, $urandom());
        cfg_we <= 1'b0;
        settings_loaded++;
    endtask

    task automatic random_settings();
        int                          kind;
        logic [ipc_pkg::SCALE_W-1:0] sc;
        logic [31:0]                 sp;
        logic [15:0]                 c0;
        logic [15:0]                 c1;
        logic [15:0]                 c2;
        logic [ipc_pkg::OUT_W-1:0]   om;
        logic [ipc_pkg::LIMIT_W-1:0] lm;
        kind = int'($urandom_range(3));
        case (kind)
            // plausible loop: setpoint inside the scaled range, moderate gains
            0, 1:
            begin
                sc = 16'($urandom_range(1, 1023));
                sp = $urandom_range(0, 4095 * sc);
                c0 = 16'($urandom_range(0, 8192) - 4096);
                c1 = 16'($urandom_range(0, 8192) - 4096);
                c2 = 16'($urandom_range(0, 8192) - 4096);
                om = 15'($urandom_range(0, 32767));
                lm = 20'($urandom_range(0, 200000));
            end
            2:
            begin
                sc = 16'($urandom());
                sp = $urandom();
                c0 = 16'($urandom());
                c1 = 16'($urandom());
                c2 = 16'($urandom());
                om = 15'($urandom());
                lm = 20'($urandom());
            end
            default:
            begin
                sc = 16'(pick_edge(32'h0, 32'hFFFF, $urandom()));
                sp = pick_edge(32'h8000_0000, 32'h7FFF_FFFF, $urandom());
                c0 = 16'(pick_edge(32'h8000, 32'h7FFF, $urandom()));
                c1 = 16'(pick_edge(32'h8000, 32'h7FFF, $urandom()));
                c2 = 16'(pick_edge(32'h8000, 32'h7FFF, $urandom()));
                om = 15'(pick_edge(32'h0, 32'h7FFF, $urandom()));
                lm = 20'(pick_edge(32'h0, 32'hFFFFF, $urandom()));
            end
        endcase
        load_settings(sc, sp, c0, c1, c2, om, lm);
    endtask

    // First sample after reset primes both error delays; reset settings
    task automatic test_first_sample();
        send_sample(12'd2048);
        send_sample(12'd0);
        send_sample(12'd4095);
        send_sample(12'd1000);
        send_sample(12'd1000);
    endtask

    // Full-scale registers: clamps at both ends, zero limits
    task automatic test_register_extremes();
        load_settings(16'hFFFF, 32'h8000_0000, 16'h7FFF, 16'h8000, 16'h7FFF,
                      15'h7FFF, 20'hFFFFF);
        send_sample(12'd4095);
        send_sample(12'd0);
        send_sample(12'd4095);
        load_settings(16'h0000, 32'h7FFF_FFFF, 16'h8000, 16'h7FFF, 16'h8000,
                      15'h0000, 20'h00000);
        send_sample(12'd0);
        send_sample(12'd4095);
        send_sample(12'd2048);
    endtask

    // Tiny products: floor of small negatives must give -1, not 0
    task automatic test_rounding();
        load_settings(16'd1, 32'd100, 16'd1, 16'hFFFF, 16'd1, 15'h7FFF, 20'd1000);
        send_sample(12'd0);
        send_sample(12'd1);
        send_sample(12'd3);
        send_sample(12'd200);
        send_sample(12'd99);
    endtask

    task automatic test_random_phase(input int idle_pct, input int stall_pct, input int n_items);
        int walk;
        walk           = int'($urandom_range(4095));
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int i = 0; i < n_items; i++)
        begin
            if (i % ITEMS_SET == 0)
                random_settings();
            case ($urandom_range(9))
                6, 7:    walk = int'($urandom_range(4095));
                8:       walk = ($urandom_range(1) == 0) ? 0 : 4095;
                9:       ;
                default: walk = walk + int'($urandom_range(64)) - 32;
            endcase
            if (walk < 0)
                walk = 0;
            else if (walk > 4095)
                walk = 4095;
            send_sample(ipc_pkg::ADC_BITS'(walk));
        end
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        test_first_sample();
        test_register_extremes();
        test_rounding();
        test_random_phase(0, 0, ITEMS_PHASE);
        test_random_phase(81, 0, ITEMS_PHASE);
        test_random_phase(0, 81, ITEMS_PHASE);
        test_random_phase(24, 24, ITEMS_PHASE);

        // drain and let the pipeline settle
        s_axis_tvalid <= 1'b0;
        while (pending_ctl_q.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);

        $display("Sent %0d samples under %0d register settings, checked %0d words",
                 samples_sent, settings_loaded, results_checked);
        $display("Idle/stall phases: none, sender, receiver, both; failures: %0d", fail_count);
        if (fail_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
